[sv/stereo_bass_treble_equalizer_defines.svh]
// ----------------------------------------------------------------------------
// Stereo bass/treble equalizer assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_BASS_TREBLE_EQUALIZER_DEFINES_SVH
`define STEREO_BASS_TREBLE_EQUALIZER_DEFINES_SVH

// Same-cycle implication
`define SBTEQ_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbteq assertion failed");

// Next-cycle implication
`define SBTEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbteq assertion failed");

`endif

[sv/sbteq_pkg.sv]
// ----------------------------------------------------------------------------
// sbteq_pkg
// Types, coefficients and the level gain table of the stereo equalizer.
// ----------------------------------------------------------------------------
package sbteq_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int IO_W            = 24;   // port width of every sample
   localparam int DATA_W          = 32;   // filter state and working width
   localparam int COEF_W          = 15;   // unsigned multiplier coefficient
   localparam int GAIN_W          = 13;   // level table entry
   localparam int PROD_W          = DATA_W - 8 + COEF_W + 1;
   localparam int PL_W            = 8 + COEF_W;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 9;
   localparam int LEVEL_W         = 4;
   localparam int VOL_W           = 9;

   localparam logic [COEF_W-1:0] PRE_SCALE = 15'd2303;
   localparam logic [COEF_W-1:0] BASS_LP_A = 15'd95;
   localparam logic [COEF_W-1:0] BASS_LP_B = 15'd4001;
   localparam logic [COEF_W-1:0] RUMBLE_A  = 15'd27;
   localparam logic [COEF_W-1:0] RUMBLE_B  = 15'd4069;
   localparam logic [COEF_W-1:0] TREBLE_A  = 15'd817;
   localparam logic [COEF_W-1:0] TREBLE_B  = 15'd3279;

   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 4'sd6;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -4'sd6;
   localparam logic [VOL_W-1:0]          VOL_MAX   = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_BASS   = 3'd1,
      CSR_TREBLE = 3'd2,
      CSR_VOLUME = 3'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      A_X, A_Y, A_RUMBLE, A_S1, A_S2, A_TT, A_HP
   } a_sel_type;

   typedef enum logic [3:0] {
      C_PRE, C_RUMBLE_A, C_RUMBLE_B, C_BASS_A, C_BASS_B, C_BASS_GAIN,
      C_TREBLE_A, C_TREBLE_B, C_TREBLE_GAIN, C_VOLUME
   } c_sel_type;

   typedef enum logic [3:0] {
      D_NONE, D_Y, D_ACC, D_RUMBLE, D_S1, D_S2, D_TT,
      D_ADJ_BASS, D_ADJ_TREBLE, D_OUT
   } dst_type;

   typedef enum logic [1:0] {
      HP_NONE, HP_RUMBLE, HP_TREBLE
   } hp_type;

   // Command word from the sequencer to both channel lanes
   typedef struct packed {
      logic      load_x;
      logic      mul_en;
      a_sel_type a_sel;
      c_sel_type c_sel;
      dst_type   dst;
      hp_type    hp_op;
      logic      clamp_en;
   } cmd_type;

   // Decoded configuration
   typedef struct packed {
      logic              bypass;
      logic              bass_on;
      logic              bass_neg;
      logic              treble_on;
      logic              treble_neg;
      logic [COEF_W-1:0] bass_mult;
      logic [COEF_W-1:0] treble_mult;
      logic [COEF_W-1:0] vol_coef;
   } cfg_type;

   function automatic logic [GAIN_W-1:0] level_gain(input logic [2:0] idx);
      logic [GAIN_W-1:0] g;
      case (idx)
         3'd0:    g = 13'd0;
         3'd1:    g = 13'd683;
         3'd2:    g = 13'd1365;
         3'd3:    g = 13'd2048;
         3'd4:    g = 13'd2731;
         3'd5:    g = 13'd3413;
         3'd6:    g = 13'd4096;
         default: g = 13'd4779;
      endcase
      return g;
   endfunction

endpackage

[sv/sbteq_csr.sv]
// ----------------------------------------------------------------------------
// sbteq_csr
// Configuration registers with write saturation and gain decoding.
// ----------------------------------------------------------------------------
module sbteq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbteq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sbteq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output sbteq_pkg::cfg_type                  cfg,
   output logic                                clear
);
   import sbteq_pkg::*;

   logic                      enable_ff, enable_in;
   logic signed [LEVEL_W-1:0] bass_ff, bass_in;
   logic signed [LEVEL_W-1:0] treble_ff, treble_in;
   logic [VOL_W-1:0]          vol_ff, vol_in;

   logic                      wr;
   logic signed [LEVEL_W-1:0] lvl_raw, lvl_sat;
   logic [VOL_W-1:0]          vol_raw;
   logic signed [LEVEL_W:0]   eb;
   logic [LEVEL_W:0]          ab;
   logic [LEVEL_W-1:0]        at;
   logic [GAIN_W-1:0]         g_b, g_t;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   // Saturate level writes and take the raw volume field
   always_comb begin
      lvl_raw = $signed(csr_wdata[LEVEL_W-1:0]);
      if (lvl_raw > LEVEL_MAX) begin
         lvl_sat = LEVEL_MAX;
      end else if (lvl_raw < LEVEL_MIN) begin
         lvl_sat = LEVEL_MIN;
      end else begin
         lvl_sat = lvl_raw;
      end
      vol_raw = csr_wdata[VOL_W-1:0];
   end

   always_comb begin
      enable_in = enable_ff;
      bass_in   = bass_ff;
      treble_in = treble_ff;
      vol_in    = vol_ff;
      clear     = 1'b0;
      if (wr) begin
         unique case (csr_index)
            CSR_ENABLE: begin
               enable_in = csr_wdata[0];
               clear     = ~csr_wdata[0];
            end
            CSR_BASS:   bass_in   = lvl_sat;
            CSR_TREBLE: treble_in = lvl_sat;
            CSR_VOLUME: vol_in    = (vol_raw > VOL_MAX) ? VOL_MAX : vol_raw;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         bass_ff   <= '0;
         treble_ff <= '0;
         vol_ff    <= VOL_MAX;
      end else begin
         enable_ff <= enable_in;
         bass_ff   <= bass_in;
         treble_ff <= treble_in;
         vol_ff    <= vol_in;
      end
   end

   // Bass level is used offset by one
   always_comb begin
      eb  = {bass_ff[LEVEL_W-1], bass_ff} + 5'sd1;
      ab  = eb[LEVEL_W] ? 5'(-eb) : 5'(eb);
      at  = treble_ff[LEVEL_W-1] ? 4'(-treble_ff) : 4'(treble_ff);
      g_b = level_gain(ab[2:0]);
      g_t = level_gain(at[2:0]);

      cfg.bass_on     = (eb != 5'sd0);
      cfg.bass_neg    = eb[LEVEL_W];
      cfg.treble_on   = (treble_ff != 4'sd0);
      cfg.treble_neg  = treble_ff[LEVEL_W-1];
      cfg.bypass      = ~enable_ff | (~cfg.bass_on & ~cfg.treble_on);
      cfg.bass_mult   = COEF_W'({g_b, 1'b0}) + COEF_W'(g_b);
      cfg.treble_mult = COEF_W'(g_t) + COEF_W'(g_t >> 2);
      cfg.vol_coef    = COEF_W'({vol_ff, 4'b0000});
   end

endmodule

[sv/sbteq_lane.sv]
// ----------------------------------------------------------------------------
// sbteq_lane
// One channel's datapath: shared Q12 multiplier, accumulator, filter state.
// ----------------------------------------------------------------------------
module sbteq_lane #(
   parameter int SAMPLE_BITS = sbteq_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  sbteq_pkg::cmd_type            cmd,
   input  sbteq_pkg::cfg_type            cfg,
   input  logic [sbteq_pkg::IO_W-1:0]    sample_in,
   output logic [sbteq_pkg::IO_W-1:0]    sample_out
);
   import sbteq_pkg::*;

   localparam int LIM_HI = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int LIM_LO = -LIM_HI - 1;
   localparam logic signed [DATA_W-1:0] LIMIT_HI = DATA_W'(LIM_HI);
   localparam logic signed [DATA_W-1:0] LIMIT_LO = DATA_W'(LIM_LO);

   logic signed [DATA_W-1:0] x_ff, x_in;
   logic signed [DATA_W-1:0] y_ff, y_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic signed [DATA_W-1:0] hp_ff, hp_in;
   logic signed [DATA_W-1:0] rumble_ff, rumble_in;
   logic signed [DATA_W-1:0] s1_ff, s1_in;
   logic signed [DATA_W-1:0] s2_ff, s2_in;
   logic signed [DATA_W-1:0] tt_ff, tt_in;
   logic signed [PROD_W-1:0] ph_ff, ph_in;
   logic [PL_W-1:0]          pl_ff, pl_in;
   logic [IO_W-1:0]          out_ff, out_in;

   logic signed [DATA_W-1:0] a_op;
   logic [COEF_W-1:0]        coef;
   logic signed [DATA_W-1:0] q;
   logic signed [DATA_W-1:0] sum;
   logic signed [DATA_W-1:0] y_clamp;

   assign x_in = {{(DATA_W - SAMPLE_BITS){sample_in[SAMPLE_BITS-1]}},
                  sample_in[SAMPLE_BITS-1:0]};

   // Operand and coefficient select
   always_comb begin
      case (cmd.a_sel)
         A_X:      a_op = x_ff;
         A_Y:      a_op = y_ff;
         A_RUMBLE: a_op = rumble_ff;
         A_S1:     a_op = s1_ff;
         A_S2:     a_op = s2_ff;
         A_TT:     a_op = tt_ff;
         A_HP:     a_op = hp_ff;
         default:  a_op = x_ff;
      endcase
      case (cmd.c_sel)
         C_PRE:         coef = PRE_SCALE;
         C_RUMBLE_A:    coef = RUMBLE_A;
         C_RUMBLE_B:    coef = RUMBLE_B;
         C_BASS_A:      coef = BASS_LP_A;
         C_BASS_B:      coef = BASS_LP_B;
         C_BASS_GAIN:   coef = cfg.bass_mult;
         C_TREBLE_A:    coef = TREBLE_A;
         C_TREBLE_B:    coef = TREBLE_B;
         C_TREBLE_GAIN: coef = cfg.treble_mult;
         C_VOLUME:      coef = cfg.vol_coef;
         default:       coef = PRE_SCALE;
      endcase
   end

   // Split Q12 product: high part signed, low byte unsigned
   assign ph_in = $signed(a_op[DATA_W-1:8]) * $signed({1'b0, coef});
   assign pl_in = a_op[7:0] * coef;

   // Recombine the registered partial products, modulo 2^32
   assign q   = ph_ff[DATA_W+3:4] + DATA_W'(pl_ff[PL_W-1:12]);
   assign sum = acc_ff + q;

   assign y_clamp = (y_ff > LIMIT_HI) ? LIMIT_HI :
                    (y_ff < LIMIT_LO) ? LIMIT_LO : y_ff;

   always_comb begin
      y_in      = y_ff;
      acc_in    = acc_ff;
      rumble_in = rumble_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      tt_in     = tt_ff;
      out_in    = out_ff;
      hp_in     = hp_ff;
      case (cmd.dst)
         D_Y:          y_in      = q;
         D_ACC:        acc_in    = q;
         D_RUMBLE:     rumble_in = sum;
         D_S1:         s1_in     = sum;
         D_S2:         s2_in     = sum;
         D_TT:         tt_in     = sum;
         D_ADJ_BASS:   y_in      = cfg.bass_neg ? y_ff - q : y_ff + q;
         D_ADJ_TREBLE: y_in      = cfg.treble_neg ? y_ff - q : y_ff + q;
         D_OUT:        out_in    = q[IO_W-1:0];
         default: ;
      endcase
      if (cmd.clamp_en) begin
         y_in = y_clamp;
      end
      case (cmd.hp_op)
         HP_RUMBLE: hp_in = y_ff - rumble_ff;
         HP_TREBLE: hp_in = y_ff - tt_ff;
         default: ;
      endcase
   end

   // Filter state: cleared by reset and by disabling the equalizer
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         rumble_ff <= '0;
         s1_ff     <= '0;
         s2_ff     <= '0;
         tt_ff     <= '0;
      end else begin
         rumble_ff <= rumble_in;
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         tt_ff     <= tt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         x_ff <= x_in;
      end
      if (cmd.mul_en) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
      y_ff   <= y_in;
      acc_ff <= acc_in;
      hp_ff  <= hp_in;
      out_ff <= out_in;
   end

   assign sample_out = out_ff;

endmodule

[sv/sbteq_ctrl.sv]
// ----------------------------------------------------------------------------
// sbteq_ctrl
// Sequencer that steps both lanes through the filter operations.
// ----------------------------------------------------------------------------
`include "stereo_bass_treble_equalizer_defines.svh"

module sbteq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sbteq_pkg::cfg_type   cfg,
   output sbteq_pkg::cmd_type   cmd
);
   import sbteq_pkg::*;

   typedef enum logic [21:0] {
      S_IDLE   = 22'h000001,
      S_PRE    = 22'h000002,
      S_PRE_WB = 22'h000004,
      S_RB     = 22'h000008,
      S_RA     = 22'h000010,
      S_RWB    = 22'h000020,
      S_HPB    = 22'h000040,
      S_B1A    = 22'h000080,
      S_B1WB   = 22'h000100,
      S_B2A    = 22'h000200,
      S_B2WB   = 22'h000400,
      S_BD     = 22'h000800,
      S_BADJ   = 22'h001000,
      S_TB     = 22'h002000,
      S_TA     = 22'h004000,
      S_TWB    = 22'h008000,
      S_HPT    = 22'h010000,
      S_TD     = 22'h020000,
      S_TADJ   = 22'h040000,
      S_CLAMP  = 22'h080000,
      S_VOL    = 22'h100000,
      S_OUT    = 22'h200000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.load_x   = 1'b0;
      cmd.mul_en   = 1'b0;
      cmd.a_sel    = A_X;
      cmd.c_sel    = C_PRE;
      cmd.dst      = D_NONE;
      cmd.hp_op    = HP_NONE;
      cmd.clamp_en = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_x = 1'b1;
               state_in   = S_PRE;
            end
         end
         S_PRE: begin
            cmd.mul_en = 1'b1;
            state_in   = S_PRE_WB;
         end
         S_PRE_WB: begin
            cmd.dst = D_Y;
            if (cfg.bypass) begin
               state_in = S_VOL;
            end else if (cfg.bass_on) begin
               state_in = S_RB;
            end else begin
               state_in = S_TB;
            end
         end
         S_RB: begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_RUMBLE;
            cmd.c_sel  = C_RUMBLE_B;
            state_in   = S_RA;
         end
         S_RA: begin
            cmd.dst    = D_ACC;
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_Y;
            cmd.c_sel  = C_RUMBLE_A;
            state_in   = S_RWB;
         end
         S_RWB: begin
            cmd.dst  = D_RUMBLE;
            state_in = S_HPB;
         end
         S_HPB: begin
            cmd.hp_op  = HP_RUMBLE;
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_S1;
            cmd.c_sel  = C_BASS_B;
            state_in   = S_B1A;
         end
         S_B1A: begin
            cmd.dst    = D_ACC;
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_HP;
            cmd.c_sel  = C_BASS_A;
            state_in   = S_B1WB;
         end
         S_B1WB: begin
            cmd.dst    = D_S1;
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_S2;
            cmd.c_sel  = C_BASS_B;
            state_in   = S_B2A;
         end
         S_B2A: begin
            cmd.dst    = D_ACC;
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_S1;
            cmd.c_sel  = C_BASS_A;
            state_in   = S_B2WB;
         end
         S_B2WB: begin
            cmd.dst  = D_S2;
            state_in = S_BD;
         end
         S_BD: begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_S2;
            cmd.c_sel  = C_BASS_GAIN;
            state_in   = S_BADJ;
         end
         S_BADJ: begin
            cmd.dst  = D_ADJ_BASS;
            state_in = cfg.treble_on ? S_TB : S_CLAMP;
         end
         S_TB: begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_TT;
            cmd.c_sel  = C_TREBLE_B;
            state_in   = S_TA;
         end
         S_TA: begin
            cmd.dst    = D_ACC;
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_Y;
            cmd.c_sel  = C_TREBLE_A;
            state_in   = S_TWB;
         end
         S_TWB: begin
            cmd.dst  = D_TT;
            state_in = S_HPT;
         end
         S_HPT: begin
            cmd.hp_op = HP_TREBLE;
            state_in  = S_TD;
         end
         S_TD: begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_HP;
            cmd.c_sel  = C_TREBLE_GAIN;
            state_in   = S_TADJ;
         end
         S_TADJ: begin
            cmd.dst  = D_ADJ_TREBLE;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp_en = 1'b1;
            state_in     = S_VOL;
         end
         S_VOL: begin
            cmd.mul_en = 1'b1;
            cmd.a_sel  = A_Y;
            cmd.c_sel  = C_VOLUME;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.dst  = D_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.dst == D_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SBTEQ_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == S_PRE)
   `SBTEQ_ASSERT_NEXT(a_result_posted, cmd.dst == D_OUT, rsp_valid_ff)
   `SBTEQ_ASSERT_IMPLIES(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)

endmodule

[sv/stereo_bass_treble_equalizer.sv]
// ----------------------------------------------------------------------------
// stereo_bass_treble_equalizer
// Time from accept to rsp_valid depends on the mode: shortest in bypass,
// then treble only, bass only, and both bands. A new pair is accepted only
// once the sequencer is idle again; each lane has one shared Q12 multiplier.
// Synchronous reset: enable 1, levels 0, volume 256, filter state zero.
// ----------------------------------------------------------------------------
module stereo_bass_treble_equalizer #(
   parameter int SAMPLE_BITS = sbteq_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input samples
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sbteq_pkg::IO_W-1:0]         req_left_in,
   input  logic [sbteq_pkg::IO_W-1:0]         req_right_in,
   // equalized samples
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sbteq_pkg::IO_W-1:0]         rsp_left_out,
   output logic [sbteq_pkg::IO_W-1:0]         rsp_right_out,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sbteq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbteq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sbteq_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    clear;

   // Register file: saturate writes, decode band gains and bypass.
   // Writing enable to 0 pulses clear, which zeroes all filter state.
   sbteq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .clear     (clear)
   );

   // Sequencer: one transaction at a time. The finished pair sits in the
   // lanes' output registers while the next transaction is accepted and
   // processed; the last step waits only if that pair is still pending.
   sbteq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cfg       (cfg),
      .cmd       (cmd)
   );

   // Both channels run in lock step on the same command word.
   sbteq_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .cmd        (cmd),
      .cfg        (cfg),
      .sample_in  (req_left_in),
      .sample_out (rsp_left_out)
   );

   sbteq_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .cmd        (cmd),
      .cfg        (cfg),
      .sample_in  (req_right_in),
      .sample_out (rsp_right_out)
   );

endmodule
